FILE: hw/rtl/rfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared constants, codes and control structs for the quartic regula falsi
// root finder.
// ----------------------------------------------------------------------------
package rfr_pkg;

    localparam int VAL_W   = 32;   // value width, signed Q16.16
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = 64;   // Horner accumulator
    localparam int ITER_W  = 10;
    localparam int TOL_W   = 31;
    localparam int NUM_COEF = 5;
    localparam int CIDX_W  = 3;
    localparam int DIV_STEPS = 64;
    localparam int DCNT_W  = 6;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_PSTART = 4'd2;
    localparam logic [3:0] OP_MLO    = 4'd3;
    localparam logic [3:0] OP_MHI    = 4'd4;
    localparam logic [3:0] OP_MACC   = 4'd5;
    localparam logic [3:0] OP_PSTORE = 4'd6;
    localparam logic [3:0] OP_CMUL   = 4'd7;
    localparam logic [3:0] OP_DIV    = 4'd8;
    localparam logic [3:0] OP_ROOT   = 4'd9;
    localparam logic [3:0] OP_UPDATE = 4'd10;
    localparam logic [3:0] OP_OUT    = 4'd11;

    // polynomial argument select
    localparam logic [1:0] SEL_XS = 2'd0;
    localparam logic [1:0] SEL_XE = 2'd1;
    localparam logic [1:0] SEL_R  = 2'd2;

    // result status
    localparam logic [1:0] ST_CONV = 2'd0;
    localparam logic [1:0] ST_CAP  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_X4  = 3'd0;
    localparam logic [2:0] CFG_X3  = 3'd1;
    localparam logic [2:0] CFG_X2  = 3'd2;
    localparam logic [2:0] CFG_X1  = 3'd3;
    localparam logic [2:0] CFG_X0  = 3'd4;
    localparam logic [2:0] CFG_TOL = 3'd5;
    localparam logic [2:0] CFG_CAP = 3'd6;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        sel;
        logic [CIDX_W-1:0] k;
        logic [ITER_W-1:0] iter;
        logic [1:0]        status;
    } rfr_cmd_t;

    typedef struct packed {
        logic              fe_eq_fs;
        logic              fr_in_tol;
        logic [ITER_W-1:0] cap;
    } rfr_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/quartic_regula_falsi_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quartic_regula_falsi_root
// Regula falsi root finder for a polynomial of degree up to four, Q16.16.
// ----------------------------------------------------------------------------
// One input transaction carries a bracket; one output transaction returns the
// root estimate, step count and status. Each polynomial evaluation runs four
// Horner steps on a split 64x32 multiplier (low half, high half, accumulate).
// Startup evaluates f at both bracket ends; each chord step is then dominated
// by the one-bit-per-cycle divider. The step cap can be set up to 1023.
// The next bracket is taken once the result is in the output register.
module quartic_regula_falsi_root
    import rfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] interval_start, [63:32] interval_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [31:0] root, [41:32] iterations, [43:42] status
);

    rfr_cmd_t  cmd;
    rfr_stat_t stat;
    logic [VAL_W-1:0]  out_root;
    logic [ITER_W-1:0] out_iter;
    logic [1:0]        out_status;

    rfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rfr_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_root   (out_root),
        .out_iter   (out_iter),
        .out_status (out_status)
    );

    assign m_tdata = {4'd0, out_status, out_iter, out_root};

endmodule
`default_nettype wire

FILE: hw/rtl/rfr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_datapath
// Config registers, bracket and f registers, split Horner multiplier,
// chord multiply and bit-serial divider, result register.
// ----------------------------------------------------------------------------
module rfr_datapath
    import rfr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [31:0]             cfg_data,
    input  wire logic [2*VAL_W-1:0]      in_data,
    input  wire rfr_cmd_t                cmd,
    output rfr_stat_t                    stat,
    output logic [VAL_W-1:0]             out_root,
    output logic [ITER_W-1:0]            out_iter,
    output logic [1:0]                   out_status
);

    logic signed [VAL_W-1:0] coef_reg [NUM_COEF];
    logic [TOL_W-1:0]        tol_reg;
    logic [ITER_W-1:0]       cap_reg;

    logic signed [VAL_W-1:0] xs_reg, xe_reg, r_reg, x_reg;
    logic signed [VAL_W-1:0] fs_reg, fe_reg, fr_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [63:0]             plo_reg, phi_reg;
    logic [63:0]             nq_reg;
    logic [VAL_W:0]          den_reg;
    logic [VAL_W:0]          rem_reg;
    logic                    qneg_reg;
    logic [VAL_W-1:0]        oroot_reg;
    logic [ITER_W-1:0]       oiter_reg;
    logic [1:0]              ostat_reg;

    // Horner step
    logic [63:0]             amag;
    logic [31:0]             xmag;
    logic                    pneg;
    logic [95:0]             mag96;
    logic [79:0]             sh;
    logic signed [63:0]      pv;
    logic signed [64:0]      sum65;
    logic signed [63:0]      acc_next;
    logic signed [VAL_W-1:0] acc_clamp;

    // chord
    logic signed [VAL_W:0]   diff33, den33;
    logic [VAL_W-1:0]        femag;
    logic [VAL_W:0]          diffmag, denmag;
    logic [64:0]             num65;
    logic [VAL_W+1:0]        trial;
    logic                    qbit;
    logic signed [65:0]      qs, rx;
    logic signed [VAL_W-1:0] r_clamp;
    logic signed [VAL_W:0]   fr33, tol33;

    always_comb begin
        amag  = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
        xmag  = x_reg[31] ? (32'd0 - x_reg) : x_reg;
        pneg  = acc_reg[63] ^ x_reg[31];
        mag96 = {32'd0, plo_reg} + {phi_reg, 32'd0};
        sh    = mag96[95:FRAC_W];
        if (pneg) begin
            if ((|sh[79:64]) || (sh[63] && (|sh[62:0]))) begin
                pv = {1'b1, 63'd0};
            end else begin
                pv = 64'd0 - sh[63:0];
            end
        end else begin
            if (|sh[79:63]) begin
                pv = {1'b0, {63{1'b1}}};
            end else begin
                pv = sh[63:0];
            end
        end
        sum65 = {pv[63], pv} + {{33{coef_reg[cmd.k][31]}}, coef_reg[cmd.k]};
        if (sum65[64] != sum65[63]) begin
            acc_next = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            acc_next = sum65[63:0];
        end
        if (acc_reg[63:31] == {33{acc_reg[63]}}) begin
            acc_clamp = acc_reg[31:0];
        end else begin
            acc_clamp = acc_reg[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end

        diff33  = {xe_reg[31], xe_reg} - {xs_reg[31], xs_reg};
        den33   = {fe_reg[31], fe_reg} - {fs_reg[31], fs_reg};
        femag   = fe_reg[31] ? (32'd0 - fe_reg) : fe_reg;
        diffmag = diff33[32] ? (33'd0 - diff33) : diff33;
        denmag  = den33[32] ? (33'd0 - den33) : den33;
        num65   = femag * diffmag;

        trial = {rem_reg, nq_reg[63]};
        qbit  = (trial >= {1'b0, den_reg});

        qs = qneg_reg ? (66'd0 - {2'b00, nq_reg}) : {2'b00, nq_reg};
        rx = {{34{xe_reg[31]}}, xe_reg} - qs;
        if (rx[65:31] == {35{rx[65]}}) begin
            r_clamp = rx[31:0];
        end else begin
            r_clamp = rx[65] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end

        fr33 = {fr_reg[31], fr_reg};
        tol33 = {2'b00, tol_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            coef_reg[3] <= 32'sd65536;
            coef_reg[4] <= '0;
            tol_reg     <= 31'd1;
            cap_reg     <= 10'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_X4:  coef_reg[0] <= cfg_data;
                CFG_X3:  coef_reg[1] <= cfg_data;
                CFG_X2:  coef_reg[2] <= cfg_data;
                CFG_X1:  coef_reg[3] <= cfg_data;
                CFG_X0:  coef_reg[4] <= cfg_data;
                CFG_TOL: tol_reg     <= cfg_data[TOL_W-1:0];
                CFG_CAP: cap_reg     <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                xs_reg <= in_data[31:0];
                xe_reg <= in_data[63:32];
                r_reg  <= in_data[63:32];
            end
            OP_PSTART: begin
                case (cmd.sel)
                    SEL_XS:  x_reg <= xs_reg;
                    SEL_XE:  x_reg <= xe_reg;
                    default: x_reg <= r_reg;
                endcase
                acc_reg <= {{32{coef_reg[0][31]}}, coef_reg[0]};
            end
            OP_MLO: plo_reg <= amag[31:0] * xmag;
            OP_MHI: phi_reg <= amag[63:32] * xmag;
            OP_MACC: acc_reg <= acc_next;
            OP_PSTORE: begin
                case (cmd.sel)
                    SEL_XS:  fs_reg <= acc_clamp;
                    SEL_XE:  fe_reg <= acc_clamp;
                    default: fr_reg <= acc_clamp;
                endcase
            end
            OP_CMUL: begin
                nq_reg   <= num65[63:0];
                den_reg  <= denmag;
                rem_reg  <= '0;
                qneg_reg <= fe_reg[31] ^ diff33[32] ^ den33[32];
            end
            OP_DIV: begin
                rem_reg <= qbit ? (trial[VAL_W:0] - den_reg) : trial[VAL_W:0];
                nq_reg  <= {nq_reg[62:0], qbit};
            end
            OP_ROOT: r_reg <= r_clamp;
            OP_UPDATE: begin
                // opposite strict signs of f(xs) and f(r): keep xs
                if ((fs_reg < 0 && fr_reg > 0) || (fs_reg > 0 && fr_reg < 0)) begin
                    xe_reg <= r_reg;
                    fe_reg <= fr_reg;
                end else begin
                    xs_reg <= r_reg;
                    fs_reg <= fr_reg;
                end
            end
            OP_OUT: begin
                oroot_reg <= r_reg;
                oiter_reg <= cmd.iter;
                ostat_reg <= cmd.status;
            end
            default: ;
        endcase
    end

    assign stat.fe_eq_fs  = (fe_reg == fs_reg);
    assign stat.fr_in_tol = (fr33 <= tol33) && (fr33 >= -tol33);
    assign stat.cap       = cap_reg;

    assign out_root   = oroot_reg;
    assign out_iter   = oiter_reg;
    assign out_status = ostat_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_ctrl
// Sequencer: polynomial evaluations, chord steps, stop tests, output valid.
// ----------------------------------------------------------------------------
module rfr_ctrl
    import rfr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire rfr_stat_t stat,
    output rfr_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_MLO    = 4'd2;
    localparam logic [3:0] S_MHI    = 4'd3;
    localparam logic [3:0] S_MACC   = 4'd4;
    localparam logic [3:0] S_PSTORE = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_ROOT   = 4'd8;
    localparam logic [3:0] S_TEST   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [1:0]        status_reg, status_next;
    logic [CIDX_W-1:0] k_reg, k_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        sel_reg, sel_next;
    logic              mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        status_next = status_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.sel     = sel_reg;
        cmd.k       = k_reg;
        cmd.iter    = iter_reg;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op      = OP_LOAD;
                    iter_next   = '0;
                    status_next = ST_CAP;
                    sel_next    = SEL_XS;
                    state_next  = S_PSTART;
                end
            end
            S_PSTART: begin
                cmd.op     = OP_PSTART;
                k_next     = 3'd1;
                state_next = S_MLO;
            end
            S_MLO: begin
                cmd.op     = OP_MLO;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.op     = OP_MHI;
                state_next = S_MACC;
            end
            S_MACC: begin
                cmd.op = OP_MACC;
                if (k_reg == 3'(NUM_COEF - 1)) begin
                    state_next = S_PSTORE;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_MLO;
                end
            end
            S_PSTORE: begin
                cmd.op = OP_PSTORE;
                case (sel_reg)
                    SEL_XS: begin
                        sel_next   = SEL_XE;
                        state_next = S_PSTART;
                    end
                    SEL_XE:  state_next = S_CHECK;
                    default: state_next = S_TEST;
                endcase
            end
            S_CHECK: begin
                if (iter_reg >= stat.cap) begin
                    status_next = ST_CAP;
                    state_next  = S_DONE;
                end else if (stat.fe_eq_fs) begin
                    status_next = ST_ZDEN;
                    state_next  = S_DONE;
                end else begin
                    cmd.op     = OP_CMUL;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                cmd.op     = OP_ROOT;
                iter_next  = iter_reg + 10'd1;
                sel_next   = SEL_R;
                state_next = S_PSTART;
            end
            S_TEST: begin
                if (stat.fr_in_tol) begin
                    status_next = ST_CONV;
                    state_next  = S_DONE;
                end else begin
                    cmd.op     = OP_UPDATE;
                    state_next = S_CHECK;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.op      = OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            iter_reg   <= '0;
            status_reg <= ST_CAP;
            k_reg      <= '0;
            cnt_reg    <= '0;
            sel_reg    <= SEL_XS;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            iter_reg   <= iter_next;
            status_reg <= status_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rfr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfr_checker
// Port-level checks for the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module rfr_checker
    import rfr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[43:42] != 2'd3)
        else $error("illegal status code");

    a_conv_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[43:42] == ST_CONV |-> m_tdata[41:32] != '0)
        else $error("converged without a step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second bracket while busy");

endmodule

bind quartic_regula_falsi_root rfr_checker u_rfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
